// ----- src/absd_pkg.sv -----
// Package for the audio block signal detector: payload structs, register
// indexes, widths and defaults shared by every module of the block.
// No dependencies.
`default_nettype none

package absd_pkg;

    // Fixed field widths
    localparam int SAMPLE_BITS    = 16;
    localparam int PEAK_OUT_BITS  = 16;
    localparam int MIN_BITS       = 32;
    localparam int PEAK_THR_BITS  = 16;
    localparam int RMS_THR_BITS   = 31;
    localparam int SUM_BITS       = 64;
    localparam int SQ_BITS        = 2 * SAMPLE_BITS;
    localparam int PEAK_CMP_BITS  =
        (SAMPLE_BITS > PEAK_THR_BITS) ? SAMPLE_BITS : PEAK_THR_BITS;

    // Defaults for module parameters
    localparam int COUNT_BITS_DEFAULT  = 32;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_SAMPLES     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PEAK_THRESHOLD  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RMS_THRESHOLD_SQ = 2'd2;

    // Register reset values
    localparam logic [MIN_BITS-1:0]      MIN_SAMPLES_RESET    = 32'd4000;
    localparam logic [PEAK_THR_BITS-1:0] PEAK_THRESHOLD_RESET = 16'd99;
    localparam logic [RMS_THR_BITS-1:0]  RMS_THR_SQ_RESET     = 31'd269;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          sample_valid;
        logic                          last_sample;
    } t_in_item;

    typedef struct packed {
        logic                     has_signal;
        logic                     too_short;
        logic [PEAK_OUT_BITS-1:0] peak_level;
    } t_out_item;

    // Classified sample as it sits in the queue: magnitude, zero if skipped
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] mag;
        logic                   last;
    } t_q_item;

    typedef struct packed {
        logic [MIN_BITS-1:0]      min_samples;
        logic [PEAK_THR_BITS-1:0] peak_threshold;
        logic [RMS_THR_BITS-1:0]  rms_threshold_squared;
    } t_cfg;

endpackage

`default_nettype wire

// ----- src/absd_front.sv -----
// Front end: input handshake and sample classification (magnitude, skip of
// non-finite samples). Depends on absd_pkg.
`default_nettype none

module absd_front (
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  absd_pkg::t_in_item  i_in_data,
    input  wire                 i_q_full,
    output logic                o_q_push,
    output absd_pkg::t_q_item   o_q_item
);
    import absd_pkg::*;

    logic [SAMPLE_BITS-1:0] raw;
    logic [SAMPLE_BITS-1:0] mag;

    // Accept whenever the queue has room
    assign o_in_ready = !i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;

    // Two's complement magnitude; the most negative code maps onto 2^(N-1)
    always_comb begin
        raw = i_in_data.sample;
        mag = raw[SAMPLE_BITS-1] ? SAMPLE_BITS'(~raw + 1'b1) : raw;
    end

    // Invalid samples still count but add nothing to peak or sum
    assign o_q_item.mag  = i_in_data.sample_valid ? mag : '0;
    assign o_q_item.last = i_in_data.last_sample;

endmodule

`default_nettype wire

// ----- src/absd_queue.sv -----
// Short FIFO between the front end and the measuring back end.
// Depends on absd_pkg.
`default_nettype none

module absd_queue #(
    parameter int DEPTH = absd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  absd_pkg::t_q_item  i_item,
    output logic               o_full,
    output logic               o_valid,
    input  wire                i_pop,
    output absd_pkg::t_q_item  o_item
);
    import absd_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);

    t_q_item             r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0] r_count,  n_count;

    assign o_full  = (r_count == CNT_BITS'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    // Pointer wrap and fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ----- src/absd_back.sv -----
// Back end: squaring stage, block accumulators (count, peak, sum of squares),
// verdict snapshot with the threshold-times-count compare, output register.
// Depends on absd_pkg.
`default_nettype none

module absd_back #(
    parameter int COUNT_BITS = absd_pkg::COUNT_BITS_DEFAULT
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  absd_pkg::t_cfg     i_cfg,
    input  wire                i_q_valid,
    output logic               o_q_pop,
    input  absd_pkg::t_q_item  i_q_item,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output absd_pkg::t_out_item o_out_data
);
    import absd_pkg::*;

    localparam int PROD_BITS = RMS_THR_BITS + COUNT_BITS;

    // Square stage
    logic                   r_sq_v;
    logic                   r_sq_last;
    logic [SAMPLE_BITS-1:0] r_sq_mag;
    logic [SQ_BITS-1:0]     r_sq;

    // Block accumulators
    logic [COUNT_BITS-1:0]  r_count, n_count;
    logic [SAMPLE_BITS-1:0] r_peak,  n_peak;
    logic [SUM_BITS-1:0]    r_sum,   n_sum;
    logic [SUM_BITS:0]      sum_ext;

    // Verdict snapshot
    logic                   r_snap_v;
    logic [COUNT_BITS-1:0]  r_snap_count;
    logic [SAMPLE_BITS-1:0] r_snap_peak;
    logic [SUM_BITS-1:0]    r_snap_sum;

    // Output register
    logic                   r_out_v;
    t_out_item              r_out;
    t_out_item              verdict;

    logic out_free, snap_go, snap_free, sq_adv, sq_free;

    // Flow control, from the output back to the queue
    assign out_free  = !r_out_v || i_out_ready;
    assign snap_go   = r_snap_v && out_free;
    assign snap_free = !r_snap_v || out_free;
    assign sq_adv    = r_sq_v && (!r_sq_last || snap_free);
    assign sq_free   = !r_sq_v || sq_adv;
    assign o_q_pop   = i_q_valid && sq_free;

    // Next accumulator values; count and sum saturate
    always_comb begin
        if (&r_count) begin
            n_count = r_count;
        end else begin
            n_count = r_count + 1'b1;
        end
        n_peak  = (r_sq_mag > r_peak) ? r_sq_mag : r_peak;
        sum_ext = {1'b0, r_sum} + (SUM_BITS + 1)'(r_sq);
        n_sum   = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
    end

    // Verdict: square root and division replaced by sum >= thr^2 * count,
    // with the threshold as it stands when the verdict is formed
    always_comb begin
        logic                 short_block;
        logic                 peak_hit;
        logic                 rms_hit;
        logic [PROD_BITS-1:0] rms_limit;
        short_block = MIN_BITS'(r_snap_count) < i_cfg.min_samples;
        peak_hit    = PEAK_CMP_BITS'(r_snap_peak) >=
                      PEAK_CMP_BITS'(i_cfg.peak_threshold);
        rms_limit   = PROD_BITS'(i_cfg.rms_threshold_squared) *
                      PROD_BITS'(r_snap_count);
        rms_hit     = r_snap_sum >= SUM_BITS'(rms_limit);
        verdict.has_signal = !short_block && (peak_hit || rms_hit);
        verdict.too_short  = short_block;
        verdict.peak_level = PEAK_OUT_BITS'(r_snap_peak);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v   <= 1'b0;
            r_snap_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_count  <= '0;
            r_peak   <= '0;
            r_sum    <= '0;
        end else begin
            if (o_q_pop) begin
                r_sq_v <= 1'b1;
            end else if (sq_adv) begin
                r_sq_v <= 1'b0;
            end

            if (sq_adv && r_sq_last) begin
                r_snap_v <= 1'b1;
            end else if (snap_go) begin
                r_snap_v <= 1'b0;
            end

            if (snap_go) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end

            // Block state clears after the last sample
            if (sq_adv) begin
                if (r_sq_last) begin
                    r_count <= '0;
                    r_peak  <= '0;
                    r_sum   <= '0;
                end else begin
                    r_count <= n_count;
                    r_peak  <= n_peak;
                    r_sum   <= n_sum;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_sq_last <= i_q_item.last;
            r_sq_mag  <= i_q_item.mag;
            r_sq      <= SQ_BITS'(i_q_item.mag) * SQ_BITS'(i_q_item.mag);
        end
        if (sq_adv && r_sq_last) begin
            r_snap_count <= n_count;
            r_snap_peak  <= n_peak;
            r_snap_sum   <= n_sum;
        end
        if (snap_go) begin
            r_out <= verdict;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ----- src/audio_block_signal_detector.sv -----
// Audio block signal detector, top level: configuration registers and the
// front end, queue and back end. Depends on absd_pkg and all absd_ modules.
//
// Use: samples arrive on the input channel (valid/ready), one transfer per
// sample, with a finiteness mark and a last mark. On each sample marked last
// one verdict transfer leaves on the output channel: has_signal, too_short
// and the block's peak magnitude. Other samples give no output.
// Throughput is one sample per cycle while the output accepts verdicts; the
// squaring multiplier and the 64-bit sum-of-squares adder each sit in their
// own register stage. A verdict passes through the queue, the square stage,
// the verdict snapshot and the output register.
// A stalled receiver holds the verdict in the output register; the queue
// (QUEUE_DEPTH entries) fills behind it and then ready drops, so nothing is
// lost. Reset clears the block state, empties the queue and loads the
// registers with their defaults (min_samples 4000, peak_threshold 99,
// rms_threshold_squared 269). The configuration port is a plain write port:
// registers are written at any edge with the write enable high and are
// meant to change only while no block is in flight.
`default_nettype none

module audio_block_signal_detector #(
    parameter int COUNT_BITS  = absd_pkg::COUNT_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = absd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_cfg_we,
    input  wire  [absd_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  wire  [absd_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    input  wire                                    i_in_valid,
    output logic                                   o_in_ready,
    input  absd_pkg::t_in_item                     i_in_data,
    output logic                                   o_out_valid,
    input  wire                                    i_out_ready,
    output absd_pkg::t_out_item                    o_out_data
);
    import absd_pkg::*;

    t_cfg    r_cfg;
    logic    q_full;
    logic    q_push;
    t_q_item q_in_item;
    logic    q_valid;
    logic    q_pop;
    t_q_item q_out_item;

    // Configuration registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_samples           <= MIN_SAMPLES_RESET;
            r_cfg.peak_threshold        <= PEAK_THRESHOLD_RESET;
            r_cfg.rms_threshold_squared <= RMS_THR_SQ_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_SAMPLES: begin
                    r_cfg.min_samples <= MIN_BITS'(i_cfg_data);
                end
                CFG_PEAK_THRESHOLD: begin
                    r_cfg.peak_threshold <= PEAK_THR_BITS'(i_cfg_data);
                end
                CFG_RMS_THRESHOLD_SQ: begin
                    r_cfg.rms_threshold_squared <= RMS_THR_BITS'(i_cfg_data);
                end
                default: begin
                end
            endcase
        end
    end

    absd_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_item   (q_in_item)
    );

    absd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (q_out_item)
    );

    absd_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_q_item    (q_out_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Testbench for audio_block_signal_detector: directed and random sample blocks
// checked against an in-bench level predictor held in a small scoreboard class.
// Depends on absd_pkg and the audio_block_signal_detector RTL.
`default_nettype none

module testbench;
    import absd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 10;   // margin for the pipeline to empty
    localparam int LONG_HOLD    = 200;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 50;
    localparam int PRESSURE_PHASE = 3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;

    // Receiver ready patterns
    typedef enum logic [1:0] {
        RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_MOSTLY
    } t_rx_mode;

    // Predicts block verdicts and checks them in order
    class level_scoreboard;
        logic [MIN_BITS-1:0]      min_len;
        logic [PEAK_THR_BITS-1:0] peak_thr;
        logic [RMS_THR_BITS-1:0]  rms_thr_sq;
        logic [31:0]              count;
        logic [SAMPLE_BITS-1:0]   peak;
        logic [SUM_BITS-1:0]      sq_sum;
        t_out_item                verdicts[$];
        int                       failures;

        function new();
            min_len    = MIN_SAMPLES_RESET;
            peak_thr   = PEAK_THRESHOLD_RESET;
            rms_thr_sq = RMS_THR_SQ_RESET;
            count      = '0;
            peak       = '0;
            sq_sum     = '0;
            failures   = 0;
        endfunction

        function void load_register(logic [CFG_INDEX_BITS-1:0] idx,
                                    logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_MIN_SAMPLES:      min_len    = data[MIN_BITS-1:0];
                CFG_PEAK_THRESHOLD:   peak_thr   = data[PEAK_THR_BITS-1:0];
                CFG_RMS_THRESHOLD_SQ: rms_thr_sq = data[RMS_THR_BITS-1:0];
                default: ;   // unknown index: ignored
            endcase
        endfunction

        // Accepted sample: update the running measures, verdict on last
        function void note_sample(t_in_item s);
            logic [SAMPLE_BITS-1:0] mag;
            logic [SUM_BITS-1:0]    sq;
            logic [63:0]            rms_limit;
            t_out_item              v;
            if (count != '1) count = count + 1;
            if (s.sample_valid) begin
                // most negative sample gives 0x8000, kept as is
                mag = s.sample[SAMPLE_BITS-1] ? (~s.sample + 16'd1) : s.sample;
                if (mag > peak) peak = mag;
                sq = 64'(mag) * 64'(mag);
                sq_sum = (sq_sum > ~64'd0 - sq) ? ~64'd0 : sq_sum + sq;
            end
            if (s.last_sample) begin
                rms_limit    = 64'(rms_thr_sq) * 64'(count);
                v.too_short  = (count < min_len);
                v.has_signal = !v.too_short && ((peak >= peak_thr) || (sq_sum >= rms_limit));
                v.peak_level = peak;
                verdicts.insert(verdicts.size(), v);
                count  = '0;
                peak   = '0;
                sq_sum = '0;
            end
        endfunction

        function void mismatch(string field, int unsigned exp, int unsigned act);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp, act);
            failures++;
        endfunction

        function void check_verdict(t_out_item got);
            t_out_item exp;
            if (verdicts.size() == 0) begin
                $display("%0t: verdict with none pending, actual %0d/%0d/%0d", $time,
                         got.has_signal, got.too_short, got.peak_level);
                failures++;
                return;
            end
            exp = verdicts.pop_front();
            if (got.has_signal !== exp.has_signal)
                mismatch("has_signal", exp.has_signal, got.has_signal);
            if (got.too_short !== exp.too_short)
                mismatch("too_short", exp.too_short, got.too_short);
            if (got.peak_level !== exp.peak_level)
                mismatch("peak_level", exp.peak_level, got.peak_level);
        endfunction

        function int pending();
            return verdicts.size();
        endfunction
    endclass

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_MIN_SAMPLES;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
    logic                      in_valid  = 1'b0;
    t_in_item                  in_data   = '0;
    logic                      out_ready = 1'b0;
    logic                      in_ready;
    logic                      out_valid;
    t_out_item                 out_data;

    level_scoreboard sb;
    t_rx_mode        rx_mode      = RX_RANDOM;
    logic            hold_request = 1'b0;
    logic            gaps_on      = 1'b1;
    int              burst_left   = 0;
    int              cycle_count;

    audio_block_signal_detector DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Verdict transfers
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_verdict(out_data);
    end

    // Receiver: long hold-off on request, otherwise the current pattern
    initial begin : receiver
        int hold_left;
        int pat;
        hold_left = 0;
        pat = 0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            pat = (pat + 1) % 5;
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS:  out_ready <= 1'b1;
                    RX_RANDOM:  out_ready <= 1'($urandom_range(0, 1));
                    RX_PATTERN: out_ready <= (pat >= 2);
                    default:    out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    function automatic t_in_item pack_sample(logic signed [SAMPLE_BITS-1:0] s,
                                             logic v, logic l);
        t_in_item it;
        it.sample       = s;
        it.sample_valid = v;
        it.last_sample  = l;
        return it;
    endfunction

    function automatic t_in_item random_sample(logic l);
        t_in_item it;
        case ($urandom_range(0, 9))
            0:       it.sample = 16'sh8000;
            1:       it.sample = 16'sh7FFF;
            2:       it.sample = 16'(int'($urandom_range(0, 6)) - 3);
            3, 4:    it.sample = 16'(int'($urandom_range(0, 800)) - 400);
            default: it.sample = 16'($urandom);
        endcase
        it.sample_valid = ($urandom_range(0, 6) != 0);
        it.last_sample  = l;
        return it;
    endfunction

    // Offer one sample, with a gap first when a burst has run out
    task automatic send_sample(t_in_item it);
        int gap;
        gap = 0;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 20);
        end else if (burst_left > 0) begin
            burst_left--;
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        sb.note_sample(it);
    endtask

    // Sender stops until every verdict is back and the pipeline is empty
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.load_register(idx, data);
        cfg_we <= 1'b0;
    endtask

    task automatic random_config();
        logic [CFG_DATA_BITS-1:0] min_len, pthr, rms;
        case ($urandom_range(0, 5))
            0:       min_len = '0;
            1:       min_len = '1;
            default: min_len = $urandom_range(1, 12);
        endcase
        case ($urandom_range(0, 6))
            0:       pthr = '0;
            1:       pthr = 32'h0000_FFFF;
            2:       pthr = 32'h0000_8000;
            3:       pthr = $urandom;
            default: pthr = $urandom_range(0, 400);
        endcase
        case ($urandom_range(0, 6))
            0:       rms = '0;
            1:       rms = '1;
            2:       rms = 32'h4000_0000;
            3:       rms = $urandom;
            default: rms = $urandom_range(0, 30000);
        endcase
        write_reg(CFG_MIN_SAMPLES, min_len);
        write_reg(CFG_PEAK_THRESHOLD, pthr);
        write_reg(CFG_RMS_THRESHOLD_SQ, rms);
        if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, $urandom);
    endtask

    initial begin : stimulus
        int block_left;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset thresholds: block far below the default minimum length
        send_sample(pack_sample(16'sh7FFF, 1'b1, 1'b0));
        send_sample(pack_sample(16'sh8000, 1'b1, 1'b0));
        send_sample(pack_sample(16'sh0000, 1'b1, 1'b1));

        // Upper register bits dropped, unknown index ignored, RMS out of reach
        drain();
        write_reg(CFG_MIN_SAMPLES, 32'd3);
        write_reg(CFG_PEAK_THRESHOLD, 32'hABCD_8000);
        write_reg(CFG_RMS_THRESHOLD_SQ, 32'hFFFF_FFFF);
        write_reg(CFG_UNUSED, 32'h1234_5678);
        // most negative sample reaches a full-scale peak threshold
        send_sample(pack_sample(16'sh8000, 1'b1, 1'b0));
        send_sample(pack_sample(16'sh0001, 1'b1, 1'b0));
        send_sample(pack_sample(16'sh0000, 1'b1, 1'b1));
        send_sample(pack_sample(16'sh7FFF, 1'b1, 1'b0));
        send_sample(pack_sample(16'sh0005, 1'b1, 1'b1));
        // invalid samples counted but not measured, invalid last included
        send_sample(pack_sample(-16'sd1, 1'b1, 1'b0));
        send_sample(pack_sample(16'sh8000, 1'b0, 1'b0));
        send_sample(pack_sample(16'sh7FFF, 1'b0, 1'b0));
        send_sample(pack_sample(16'sd100, 1'b0, 1'b1));
        send_sample(pack_sample(16'sh0000, 1'b1, 1'b1));
        // block left open across a register change
        send_sample(pack_sample(-16'sd20000, 1'b1, 1'b0));
        send_sample(pack_sample(16'sd300, 1'b1, 1'b0));

        drain();
        write_reg(CFG_MIN_SAMPLES, 32'd0);
        write_reg(CFG_PEAK_THRESHOLD, 32'h0000_FFFF);
        write_reg(CFG_RMS_THRESHOLD_SQ, 32'd0);
        send_sample(pack_sample(16'sd7, 1'b1, 1'b1));
        send_sample(pack_sample(16'sh0000, 1'b0, 1'b1));

        // Longest minimum: every block short
        drain();
        write_reg(CFG_MIN_SAMPLES, 32'hFFFF_FFFF);
        write_reg(CFG_PEAK_THRESHOLD, 32'd0);
        write_reg(CFG_RMS_THRESHOLD_SQ, 32'd269);
        send_sample(pack_sample(16'sd12345, 1'b1, 1'b0));
        send_sample(pack_sample(-16'sd12345, 1'b1, 1'b1));

        // Peak threshold either side of the edge, RMS at unity
        drain();
        write_reg(CFG_MIN_SAMPLES, 32'd1);
        write_reg(CFG_PEAK_THRESHOLD, 32'd99);
        write_reg(CFG_RMS_THRESHOLD_SQ, 32'h4000_0000);
        send_sample(pack_sample(16'sd98, 1'b1, 1'b1));
        send_sample(pack_sample(-16'sd99, 1'b1, 1'b1));

        // RMS compare exactly at, and just below, the threshold
        drain();
        write_reg(CFG_PEAK_THRESHOLD, 32'h0000_FFFF);
        send_sample(pack_sample(16'sh8000, 1'b1, 1'b1));
        send_sample(pack_sample(16'sh7FFF, 1'b1, 1'b1));
        send_sample(pack_sample(16'sh8000, 1'b1, 1'b0));
        send_sample(pack_sample(16'sh8000, 1'b0, 1'b1));

        // Random phases; a block may straddle a phase boundary
        block_left = $urandom_range(1, 10);
        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            random_config();
            rx_mode = t_rx_mode'(phase % 4);
            gaps_on = (phase != PRESSURE_PHASE) && (phase != PHASES - 1);
            burst_left = 0;
            @(posedge clk);
            if (phase == PRESSURE_PHASE) hold_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                block_left--;
                send_sample(random_sample(block_left == 0));
                if (block_left == 0)
                    block_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                              : $urandom_range(1, 10);
                // mid-phase pause for all outstanding verdicts
                if (phase == 1 && n == PHASE_ITEMS / 2) drain();
            end
        end

        drain();
        if (sb.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
